>>> sv/ffa_pkg.sv
package ffa_pkg;

   localparam int unsigned ARENA_BYTES = 8192;
   localparam int unsigned HDR_BYTES   = 8;

   localparam int unsigned REQ_W  = 14;
   localparam int unsigned OFF_W  = 13;
   localparam int unsigned ADDR_W = $clog2(ARENA_BYTES);
   localparam int unsigned PTR_W  = $clog2(ARENA_BYTES + 1);
   localparam int unsigned SZ_W   = (ADDR_W > REQ_W) ? ADDR_W : REQ_W;
   localparam int unsigned NEED_W = REQ_W + 1;
   localparam int unsigned EXT_W  = ((ADDR_W > SZ_W) ? ADDR_W : SZ_W) + 2;

   localparam logic [PTR_W-1:0] NONE_MARK = PTR_W'(ARENA_BYTES);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   typedef struct packed {
      logic             command;
      logic [REQ_W-1:0] request_size;
      logic [OFF_W-1:0] block_offset;
   } ffa_req_type;

   typedef struct packed {
      logic [OFF_W-1:0] payload_offset;
      logic             status;
   } ffa_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_CHECK,
      ST_A_READ,
      ST_A_SPLIT,
      ST_A_LINK,
      ST_A_DONE,
      ST_F_CHECK,
      ST_F_READ,
      ST_F_LINK1,
      ST_F_LINK2
   } ffa_state_type;

endpackage

>>> sv/first_fit_arena_allocator_core.sv
// First-fit arena allocator. A request is taken when start is high and busy is
// low; its single result appears on rsp_data for exactly one cycle with
// rsp_valid high, and the receiver cannot stall it. An allocate visits the
// free-list nodes in order, each visit an address state and a registered
// read state, then splits if needed, relinks and answers; a free visits the
// free-list nodes lying below the block the same way, then links it in and
// answers. The steps are set by the single-port header store, whose reads
// are registered. After reset the block stays busy while it clears all
// ARENA_BYTES (8192) entries of the header store, one entry a cycle.
module first_fit_arena_allocator_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ffa_pkg::ffa_req_type req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output ffa_pkg::ffa_rsp_type rsp_data
);

   import ffa_pkg::*;

   ffa_state_type state_ff, state_in;

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [REQ_W-1:0]  req_size_ff, req_size_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [PTR_W-1:0]  hdr_ff, hdr_in;
   logic              bad_ff, bad_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  cur_ff, cur_in;
   logic [PTR_W-1:0]  prev_ff, prev_in;
   logic [PTR_W-1:0]  steps_ff, steps_in;
   logic [SZ_W-1:0]   sz_ff, sz_in;
   logic [PTR_W-1:0]  nf_ff, nf_in;
   logic [ADDR_W-1:0] rem_ff, rem_in;
   logic              split_ff, split_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ffa_rsp_type       rsp_ff, rsp_in;

   logic              size_we;
   logic [ADDR_W-1:0] size_addr;
   logic [SZ_W-1:0]   size_wdata;
   logic [SZ_W-1:0]   size_rd;
   logic              next_we;
   logic [ADDR_W-1:0] next_addr;
   logic [PTR_W-1:0]  next_wdata;
   logic [PTR_W-1:0]  next_rd;

   logic              cur_is_node;
   logic              prev_is_node;
   logic              clr_last;
   logic              steps_full;
   logic              free_walk;
   logic [EXT_W-1:0]  extent;
   logic              too_small;
   logic              exact_fit;
   logic              accept;
   logic [PTR_W-1:0]  link_val;

   ffa_ram #(
      .WIDTH (SZ_W),
      .DEPTH (ARENA_BYTES)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (size_we),
      .addr    (size_addr),
      .wr_data (size_wdata),
      .rd_data (size_rd)
   );

   ffa_ram #(
      .WIDTH (PTR_W),
      .DEPTH (ARENA_BYTES)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .addr    (next_addr),
      .wr_data (next_wdata),
      .rd_data (next_rd)
   );

   assign accept       = start && (state_ff == ST_IDLE);
   assign cur_is_node  = cur_ff < NONE_MARK;
   assign prev_is_node = prev_ff < NONE_MARK;
   assign clr_last     = clr_ff == ADDR_W'(ARENA_BYTES - 1);
   assign steps_full   = steps_ff == PTR_W'(ARENA_BYTES);
   assign free_walk    = cur_is_node && (cur_ff < hdr_ff);
   assign extent       = EXT_W'(cur_ff[ADDR_W-1:0]) + EXT_W'(HDR_BYTES) + EXT_W'(size_rd);
   assign too_small    = (EXT_W'(size_rd) < EXT_W'(need_ff))
                         || (extent > EXT_W'(ARENA_BYTES));
   assign exact_fit    = EXT_W'(size_rd) == EXT_W'(need_ff);
   assign link_val     = split_ff ? PTR_W'(rem_ff) : nf_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = (req_data.command == CMD_ALLOC) ? ST_A_CHECK : ST_F_CHECK;
            end
         end
         ST_A_CHECK: begin
            state_in = (!cur_is_node || steps_full) ? ST_IDLE : ST_A_READ;
         end
         ST_A_READ: begin
            if (too_small) begin
               state_in = ST_A_CHECK;
            end else if (exact_fit) begin
               state_in = ST_A_LINK;
            end else begin
               state_in = ST_A_SPLIT;
            end
         end
         ST_A_SPLIT: state_in = ST_A_LINK;
         ST_A_LINK:  state_in = ST_A_DONE;
         ST_A_DONE:  state_in = ST_IDLE;
         ST_F_CHECK: begin
            if (bad_ff) begin
               state_in = ST_IDLE;
            end else if (free_walk) begin
               state_in = steps_full ? ST_IDLE : ST_F_READ;
            end else begin
               state_in = (cur_ff == hdr_ff) ? ST_IDLE : ST_F_LINK1;
            end
         end
         ST_F_READ:  state_in = ST_F_CHECK;
         ST_F_LINK1: state_in = ST_F_LINK2;
         ST_F_LINK2: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      clr_in       = clr_ff;
      req_size_in  = req_size_ff;
      need_in      = need_ff;
      hdr_in       = hdr_ff;
      bad_in       = bad_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      sz_in        = sz_ff;
      nf_in        = nf_ff;
      rem_in       = rem_ff;
      split_in     = split_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      size_we      = 1'b0;
      size_addr    = cur_ff[ADDR_W-1:0];
      size_wdata   = SZ_W'(req_size_ff);
      next_we      = 1'b0;
      next_addr    = cur_ff[ADDR_W-1:0];
      next_wdata   = NONE_MARK;
      case (state_ff)
         ST_CLEAR: begin
            size_we    = 1'b1;
            size_addr  = clr_ff;
            size_wdata = (clr_ff == '0) ? SZ_W'(ARENA_BYTES - HDR_BYTES) : '0;
            next_we    = 1'b1;
            next_addr  = clr_ff;
            next_wdata = NONE_MARK;
            clr_in     = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               req_size_in = req_data.request_size;
               need_in     = NEED_W'(req_data.request_size) + NEED_W'(HDR_BYTES);
               hdr_in      = PTR_W'(EXT_W'(req_data.block_offset) - EXT_W'(HDR_BYTES));
               bad_in      = (EXT_W'(req_data.block_offset) < EXT_W'(HDR_BYTES))
                             || ((EXT_W'(req_data.block_offset) - EXT_W'(HDR_BYTES))
                                 >= EXT_W'(ARENA_BYTES));
               cur_in      = head_ff;
               prev_in     = NONE_MARK;
               steps_in    = '0;
            end
         end
         ST_A_CHECK: begin
            if (!cur_is_node || steps_full) begin
               rsp_valid_in          = 1'b1;
               rsp_in.payload_offset = '0;
               rsp_in.status         = STATUS_NO_SPACE;
            end
         end
         ST_A_READ: begin
            steps_in = steps_ff + 1'b1;
            sz_in    = size_rd;
            nf_in    = next_rd;
            split_in = !exact_fit;
            rem_in   = ADDR_W'(EXT_W'(cur_ff[ADDR_W-1:0]) + EXT_W'(need_ff));
            if (too_small) begin
               prev_in = cur_ff;
               cur_in  = next_rd;
            end
         end
         ST_A_SPLIT: begin
            size_we    = 1'b1;
            size_addr  = rem_ff;
            size_wdata = SZ_W'(EXT_W'(sz_ff) - EXT_W'(need_ff));
            next_we    = 1'b1;
            next_addr  = rem_ff;
            next_wdata = nf_ff;
         end
         ST_A_LINK: begin
            size_we    = split_ff;
            size_addr  = cur_ff[ADDR_W-1:0];
            size_wdata = SZ_W'(req_size_ff);
            next_addr  = prev_ff[ADDR_W-1:0];
            next_wdata = link_val;
            if (prev_is_node) begin
               next_we = 1'b1;
            end else begin
               head_in = link_val;
            end
         end
         ST_A_DONE: begin
            next_we               = 1'b1;
            next_addr             = cur_ff[ADDR_W-1:0];
            next_wdata            = NONE_MARK;
            rsp_valid_in          = 1'b1;
            rsp_in.payload_offset = OFF_W'(EXT_W'(cur_ff[ADDR_W-1:0]) + EXT_W'(HDR_BYTES));
            rsp_in.status         = STATUS_DONE;
         end
         ST_F_CHECK: begin
            if (bad_ff || (free_walk && steps_full) || (!free_walk && cur_ff == hdr_ff)) begin
               rsp_valid_in          = 1'b1;
               rsp_in.payload_offset = '0;
               rsp_in.status         = STATUS_DONE;
            end
         end
         ST_F_READ: begin
            steps_in = steps_ff + 1'b1;
            prev_in  = cur_ff;
            cur_in   = next_rd;
         end
         ST_F_LINK1: begin
            next_we    = 1'b1;
            next_addr  = hdr_ff[ADDR_W-1:0];
            next_wdata = cur_ff;
         end
         ST_F_LINK2: begin
            next_addr  = prev_ff[ADDR_W-1:0];
            next_wdata = hdr_ff;
            if (prev_is_node) begin
               next_we = 1'b1;
            end else begin
               head_in = hdr_ff;
            end
            rsp_valid_in          = 1'b1;
            rsp_in.payload_offset = '0;
            rsp_in.status         = STATUS_DONE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_size_ff <= req_size_in;
      need_ff     <= need_in;
      hdr_ff      <= hdr_in;
      bad_ff      <= bad_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      steps_ff    <= steps_in;
      sz_ff       <= sz_in;
      nf_ff       <= nf_in;
      rem_ff      <= rem_in;
      split_ff    <= split_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_returns_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result strobe without return to idle");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not start the sequencer");

   a_no_space_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_NO_SPACE) |-> rsp_ff.payload_offset == '0)
      else $error("no-space result carries an offset");

   a_fit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A_LINK || state_ff == ST_A_DONE)
      |-> (EXT_W'(sz_ff) >= EXT_W'(need_ff)) && cur_is_node)
      else $error("allocation proceeding on a block that does not fit");
`endif

endmodule

>>> sv/ffa_ram.sv
module ffa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end

   assign rd_data = rd_ff;

endmodule

>>> dv/first_fit_arena_allocator_checker.sv
`timescale 1ns / 100ps
module first_fit_arena_allocator_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  ffa_pkg::ffa_req_type req_data,
   input  logic                 rsp_valid,
   input  ffa_pkg::ffa_rsp_type rsp_data,
   output int                   fail_count,
   output int                   pending
);

   import ffa_pkg::*;

   logic [SZ_W-1:0]  size_mem [ARENA_BYTES];
   logic [PTR_W-1:0] link_mem [ARENA_BYTES];
   logic [PTR_W-1:0] free_head;
   ffa_rsp_type      rsp_due_q [$];

   function automatic void relink(input int unsigned prev, input int unsigned target);
      if (prev < ARENA_BYTES) begin
         link_mem[prev] = PTR_W'(target);
      end else begin
         free_head = PTR_W'(target);
      end
   endfunction

   function automatic ffa_rsp_type carve_block(input logic [REQ_W-1:0] want);
      int unsigned need;
      int unsigned prev;
      int unsigned cur;
      int unsigned steps;
      int unsigned sz;
      int unsigned rem;
      ffa_rsp_type outcome;
      need = want + HDR_BYTES;
      prev = ARENA_BYTES;
      cur = free_head;
      steps = 0;
      outcome.payload_offset = '0;
      outcome.status = STATUS_NO_SPACE;
      while (cur < ARENA_BYTES && steps < ARENA_BYTES) begin
         sz = size_mem[cur];
         steps++;
         if (sz < need || cur + HDR_BYTES + sz > ARENA_BYTES) begin
            prev = cur;
            cur = link_mem[cur];
         end else begin
            if (sz == need) begin
               relink(prev, link_mem[cur]);
            end else begin
               // split: the remainder takes over the list position
               rem = cur + need;
               size_mem[rem] = SZ_W'(sz - need);
               link_mem[rem] = link_mem[cur];
               size_mem[cur] = SZ_W'(want);
               relink(prev, rem);
            end
            link_mem[cur] = NONE_MARK;
            outcome.payload_offset = OFF_W'(cur + HDR_BYTES);
            outcome.status = STATUS_DONE;
            break;
         end
      end
      return outcome;
   endfunction

   function automatic void release_block(input logic [OFF_W-1:0] off);
      int unsigned hdr;
      int unsigned prev;
      int unsigned cur;
      int unsigned steps;
      if (off < HDR_BYTES) return;
      hdr = off - HDR_BYTES;
      if (hdr >= ARENA_BYTES) return;
      prev = ARENA_BYTES;
      cur = free_head;
      steps = 0;
      while (cur < ARENA_BYTES && cur < hdr) begin
         if (steps >= ARENA_BYTES) return;
         steps++;
         prev = cur;
         cur = link_mem[cur];
      end
      if (cur == hdr) return;
      if (prev < ARENA_BYTES) begin
         link_mem[hdr] = link_mem[prev];
         link_mem[prev] = PTR_W'(hdr);
      end else begin
         link_mem[hdr] = free_head;
         free_head = PTR_W'(hdr);
      end
   endfunction

   always @(posedge clock) begin : watch
      ffa_rsp_type due;
      if (reset) begin
         for (int i = 0; i < ARENA_BYTES; i++) begin
            size_mem[i] = '0;
            link_mem[i] = NONE_MARK;
         end
         size_mem[0] = SZ_W'(ARENA_BYTES - HDR_BYTES);
         free_head = '0;
         rsp_due_q.delete();
         fail_count = 0;
         pending = 0;
      end else begin
         if (rsp_valid) begin
            if (rsp_due_q.size() == 0) begin
               fail_count++;
               $display("%0t: response with none due: expected nothing, got offset %0d status %0d",
                        $time, rsp_data.payload_offset, rsp_data.status);
            end else begin
               due = rsp_due_q.pop_front();
               if (rsp_data.payload_offset !== due.payload_offset) begin
                  fail_count++;
                  $display("%0t: payload_offset mismatch: expected %0d, got %0d",
                           $time, due.payload_offset, rsp_data.payload_offset);
               end
               if (rsp_data.status !== due.status) begin
                  fail_count++;
                  $display("%0t: status mismatch: expected %0d, got %0d",
                           $time, due.status, rsp_data.status);
               end
            end
         end
         if (start && !busy) begin
            if (req_data.command == CMD_FREE) begin
               release_block(req_data.block_offset);
               due.payload_offset = '0;
               due.status = STATUS_DONE;
            end else begin
               due = carve_block(req_data.request_size);
            end
            rsp_due_q.push_back(due);
         end
         pending = rsp_due_q.size();
      end
   end

endmodule

>>> dv/first_fit_arena_allocator_core_tb.sv
`timescale 1ns / 100ps
module first_fit_arena_allocator_core_tb;

   import ffa_pkg::*;

   localparam int unsigned RANDOM_COUNT  = 1830;
   localparam int unsigned CALM_TAIL     = 150;
   localparam int unsigned HELD_CAP      = 48;
   localparam int unsigned STALL_LIMIT   = 100000;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned REQ_MAX       = (1 << REQ_W) - 1;
   localparam int unsigned OFF_MAX       = (1 << OFF_W) - 1;
   localparam int unsigned PIN_BYTES     = 200;
   localparam int unsigned PIN_OFFSET    = HDR_BYTES;
   localparam int unsigned PIN_INNER     = PIN_OFFSET + 72;

   typedef struct {
      int unsigned offset;
      int unsigned bytes;
   } block_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   ffa_req_type req_data = '0;
   logic        busy;
   logic        rsp_valid;
   ffa_rsp_type rsp_data;
   int          fail_count;
   int          pending;
   int          stall_cycles = 0;

   ffa_req_type issued_q [$];
   block_type   held_q [$];
   block_type   released_q [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   first_fit_arena_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   first_fit_arena_allocator_checker arena_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   task automatic send_request(input logic cmd, input int unsigned want,
                               input int unsigned off);
      ffa_req_type item;
      item.command = cmd;
      item.request_size = REQ_W'(want);
      item.block_offset = OFF_W'(off);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic free_held(input int idx);
      block_type picked;
      picked = held_q[idx];
      held_q.delete(idx);
      released_q.push_back(picked);
      send_request(CMD_FREE, $urandom_range(0, REQ_MAX), picked.offset);
   endtask

   task automatic pause_idle(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // follow the blocks handed out so frees target real allocations
   always @(posedge clock) begin : track
      ffa_req_type answered;
      block_type   fresh;
      int          hit;
      if (!reset) begin
         if (rsp_valid && issued_q.size() > 0) begin
            answered = issued_q.pop_front();
            if (answered.command == CMD_ALLOC && rsp_data.status == STATUS_DONE
                && rsp_data.payload_offset != PIN_OFFSET) begin
               fresh.offset = rsp_data.payload_offset;
               fresh.bytes = answered.request_size;
               hit = -1;
               foreach (released_q[k]) begin
                  if (released_q[k].offset == fresh.offset) hit = k;
               end
               if (hit >= 0) begin
                  if (released_q[hit].bytes == fresh.bytes + HDR_BYTES) begin
                     fresh.bytes = released_q[hit].bytes;
                  end
                  released_q.delete(hit);
               end
               held_q.push_back(fresh);
            end
         end
         if (start && !busy) issued_q.push_back(req_data);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or response for %0d cycles", $time, stall_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      int          mark;
      int          pick;
      int          shape;
      int          j;
      int unsigned want;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_request(CMD_ALLOC, PIN_BYTES, 0);
      send_request(CMD_ALLOC, 0, 0);
      send_request(CMD_ALLOC, ARENA_BYTES, 0);
      send_request(CMD_ALLOC, REQ_MAX, OFF_MAX);
      send_request(CMD_FREE, 0, 0);
      send_request(CMD_FREE, 0, HDR_BYTES - 1);
      send_request(CMD_FREE, 0, PIN_INNER);
      send_request(CMD_ALLOC, 40, 0);
      drain();
      free_held(held_q.size() - 1);
      send_request(CMD_FREE, 0, released_q[$].offset);
      send_request(CMD_ALLOC, 32, 0);
      send_request(CMD_ALLOC, 100, 0);
      drain();
      mark = held_q.size() - 1;
      send_request(CMD_ALLOC, 50, 0);
      free_held(mark);
      send_request(CMD_ALLOC, 60, 0);

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         pick = $urandom_range(0, 99);
         if (held_q.size() > 0 && (held_q.size() > HELD_CAP || pick < 38)) begin
            free_held($urandom_range(0, held_q.size() - 1));
         end else if (pick < 41 && released_q.size() > 0) begin
            j = $urandom_range(0, released_q.size() - 1);
            send_request(CMD_FREE, $urandom_range(0, REQ_MAX), released_q[j].offset);
         end else if (pick < 43) begin
            send_request(CMD_FREE, $urandom_range(0, REQ_MAX),
                         $urandom_range(0, HDR_BYTES - 1));
         end else begin
            shape = $urandom_range(0, 99);
            want = $urandom_range(1, 160);
            if (shape < 45 && released_q.size() > 0) begin
               j = $urandom_range(0, released_q.size() - 1);
               if (released_q[j].bytes >= HDR_BYTES) want = released_q[j].bytes - HDR_BYTES;
            end else if (shape >= 97) begin
               want = $urandom_range(ARENA_BYTES - HDR_BYTES + 1, REQ_MAX);
            end else if (shape >= 88) begin
               want = $urandom_range(161, 1200);
            end
            send_request(CMD_ALLOC, want, $urandom_range(0, OFF_MAX));
         end
         if (n == RANDOM_COUNT / 2) begin
            drain();
         end else if (n + CALM_TAIL < RANDOM_COUNT && $urandom_range(0, 3) == 0) begin
            pause_idle($urandom_range(1, 3));
         end
      end

      // unsort the list around the pinned block, then close a loop in it
      send_request(CMD_FREE, 0, PIN_OFFSET);
      send_request(CMD_ALLOC, 100, 0);
      send_request(CMD_FREE, 0, PIN_INNER);
      send_request(CMD_ALLOC, REQ_MAX, 0);
      send_request(CMD_FREE, REQ_MAX, OFF_MAX);
      send_request(CMD_ALLOC, 50, 0);

      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending != 0) $display("%0t: %0d responses never arrived", $time, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/ffa_pkg.sv
sv/ffa_ram.sv
sv/first_fit_arena_allocator_core.sv
dv/first_fit_arena_allocator_checker.sv
dv/first_fit_arena_allocator_core_tb.sv
